FILE: hdl/fpds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fpds_pkg;

    // Field widths.
    localparam int KIND_W   = 1;
    localparam int RATE_IN_W = 32;
    localparam int OUT_W    = 5;
    localparam int INT_W    = 7;
    localparam int FRAC_W   = 24;
    localparam int RATE_W   = 42;
    localparam int PARENT_W = 32;

    // The solve divides target * 2^24 by 4*parent.
    localparam int DEN_W     = PARENT_W + 2;
    localparam int SOLVE_NB  = RATE_IN_W + FRAC_W;
    // 4*parent*(int+1) needs at most 41 bits.
    localparam int WHOLE_W   = DEN_W + INT_W;
    // floor(parent*frac / 2^22) needs at most 34 bits.
    localparam int PART_SHIFT = FRAC_W - 2;
    localparam int PART_W    = PARENT_W + FRAC_W - PART_SHIFT;
    localparam int QDIV_W    = OUT_W + 1;

    localparam int MULT_MAX = 128;

    localparam logic [PARENT_W-1:0] PARENT_RESET = 32'd24000000;

    // Steps of restoring division done in each pipeline stage.
    localparam int SOLVE_STEPS_DEF = 2;
    localparam int RATE_STEPS_DEF  = 4;

    // Kind codes.
    localparam logic KIND_SOLVE = 1'b0;
    localparam logic KIND_CALC  = 1'b1;

    // Request carried alongside the solve division.
    typedef struct packed {
        logic                kind;
        logic [OUT_W-1:0]    out_div;
        logic [INT_W-1:0]    int_div;
        logic [FRAC_W-1:0]   frac_div;
        logic [PARENT_W-1:0] parent;
    } req_t;

    // Result fields carried alongside the rate divisions.
    typedef struct packed {
        logic [OUT_W-1:0]  out_div;
        logic [INT_W-1:0]  int_div;
        logic [FRAC_W-1:0] frac_div;
        logic              err;
    } fields_t;

endpackage : fpds_pkg

`default_nettype wire

FILE: hdl/frac_pll_divider_solver_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Fractional-N PLL divider solver. Each transfer on the s_ side is one request and
// produces one transfer on the m_ side, in order. Kind 0 solves integer and fractional
// dividers for a target rate (output divider 0); kind 1 computes the rate from given
// fields. A new request is taken every cycle unless the output buffer is full; the depth
// of the pipeline is set by the two pipelined restoring dividers: the 56-bit solve
// division and the 41-bit rate division by the output divider. A two-entry output
// buffer keeps the pipeline moving while a result waits for m_tready. parent_rate_hz is
// written through cfg_we / cfg_wdata and resets to 24 MHz. The user must write it only
// while the block is idle; the block itself does not enforce this.
module frac_pll_divider_solver_top
    import fpds_pkg::*;
#(
    parameter int SOLVE_STEPS = SOLVE_STEPS_DEF,
    parameter int RATE_STEPS  = RATE_STEPS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // target_rate_hz[31:0], out_div_in[36:32], int_div_in[43:37], frac_div_in[67:44]
    input  wire logic [71:0] s_tdata,
    // kind[0]
    input  wire logic [0:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // out_div_field[4:0], int_div_field[11:5], frac_div_field[35:12], rate_hz[77:36]
    output logic [79:0]      m_tdata,
    // error[0]
    output logic [0:0]       m_tuser
);

    localparam int OUT_DW = OUT_W + INT_W + FRAC_W + RATE_W;

    logic                 en;
    logic [PARENT_W-1:0]  parent_reg;

    logic                 in_v_reg;
    req_t                 in_req_reg;
    logic [RATE_IN_W-1:0] in_target_reg;

    logic                 sv_valid;
    logic [SOLVE_NB-1:0]  sv_quo;
    req_t                 sv_req;

    logic                 rp_valid;
    logic [WHOLE_W-1:0]   rp_whole;
    logic [PART_W-1:0]    rp_part;
    logic [QDIV_W-1:0]    rp_qdiv;
    fields_t              rp_fields;

    logic                 qa_valid;
    logic [WHOLE_W-1:0]   qa_quo;
    fields_t              qa_fields;
    logic [WHOLE_W-1:0]   qb_quo;
    logic [0:0]           qb_err;

    logic                 fin_v_reg;
    logic [OUT_DW-1:0]    fin_data_reg;
    logic                 fin_err_reg;
    logic [RATE_W-1:0]    rate_next;

    logic                 out_valid_reg;
    logic [OUT_DW-1:0]    out_data_reg;
    logic                 out_err_reg;
    logic                 skid_valid_reg;
    logic [OUT_DW-1:0]    skid_data_reg;
    logic                 skid_err_reg;
    logic                 out_valid_next;
    logic                 skid_valid_next;
    logic                 take;
    logic                 ld_out_skid;
    logic                 ld_out_pipe;
    logic                 ld_skid;

    // The whole pipeline moves unless the output buffer is full.
    assign en       = ~skid_valid_reg;
    assign s_tready = en;

    // Parent rate register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parent_reg <= PARENT_RESET;
        end else if (cfg_we) begin
            parent_reg <= cfg_wdata;
        end
    end

    // Input stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (en) begin
            in_v_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_target_reg       <= s_tdata[31:0];
            in_req_reg.kind     <= s_tuser[0];
            in_req_reg.out_div  <= s_tdata[36:32];
            in_req_reg.int_div  <= s_tdata[43:37];
            in_req_reg.frac_div <= s_tdata[67:44];
            in_req_reg.parent   <= parent_reg;
        end
    end

    // Solve: floor(target * 2^24 / (4 * parent)) gives multiplier and fraction at once.
    fpds_div_pipe #(
        .NB  (SOLVE_NB),
        .DW  (DEN_W),
        .SPS (SOLVE_STEPS),
        .PW  ($bits(req_t))
    ) u_solve_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (in_v_reg),
        .in_num    ({in_target_reg, {FRAC_W{1'b0}}}),
        .in_den    ({in_req_reg.parent, 2'b00}),
        .in_pay    (in_req_reg),
        .out_valid (sv_valid),
        .out_quo   (sv_quo),
        .out_pay   (sv_req)
    );

    fpds_rate_prep u_rate_prep (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (sv_valid),
        .in_quo     (sv_quo),
        .in_req     (sv_req),
        .out_valid  (rp_valid),
        .out_whole  (rp_whole),
        .out_part   (rp_part),
        .out_qdiv   (rp_qdiv),
        .out_fields (rp_fields)
    );

    // Whole part of the rate divided by (out + 1).
    fpds_div_pipe #(
        .NB  (WHOLE_W),
        .DW  (QDIV_W),
        .SPS (RATE_STEPS),
        .PW  ($bits(fields_t))
    ) u_whole_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (rp_valid),
        .in_num    (rp_whole),
        .in_den    (rp_qdiv),
        .in_pay    (rp_fields),
        .out_valid (qa_valid),
        .out_quo   (qa_quo),
        .out_pay   (qa_fields)
    );

    // Fractional part of the rate divided by (out + 1), same latency.
    fpds_div_pipe #(
        .NB  (WHOLE_W),
        .DW  (QDIV_W),
        .SPS (RATE_STEPS),
        .PW  (1)
    ) u_part_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (rp_valid),
        .in_num    ({{(WHOLE_W-PART_W){1'b0}}, rp_part}),
        .in_den    (rp_qdiv),
        .in_pay    (rp_fields.err),
        .out_valid (),
        .out_quo   (qb_quo),
        .out_pay   (qb_err)
    );

    // Final sum; an out-of-range solve reports a zero rate.
    assign rate_next = qb_err[0] ? '0 :
                       RATE_W'(qa_quo) + RATE_W'(qb_quo[PART_W-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_v_reg <= 1'b0;
        end else if (en) begin
            fin_v_reg <= qa_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fin_data_reg <= {rate_next, qa_fields.frac_div, qa_fields.int_div,
                             qa_fields.out_div};
            fin_err_reg  <= qa_fields.err;
        end
    end

    // Output register with a skid entry behind it.
    always_comb begin
        take            = out_valid_reg & m_tready;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        ld_out_skid     = 1'b0;
        ld_out_pipe     = 1'b0;
        ld_skid         = 1'b0;
        if (skid_valid_reg) begin
            if (take) begin
                ld_out_skid     = 1'b1;
                skid_valid_next = 1'b0;
            end
        end else if (fin_v_reg) begin
            if (!out_valid_reg || take) begin
                ld_out_pipe    = 1'b1;
                out_valid_next = 1'b1;
            end else begin
                ld_skid         = 1'b1;
                skid_valid_next = 1'b1;
            end
        end else if (take) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_out_skid) begin
            out_data_reg <= skid_data_reg;
            out_err_reg  <= skid_err_reg;
        end else if (ld_out_pipe) begin
            out_data_reg <= fin_data_reg;
            out_err_reg  <= fin_err_reg;
        end
        if (ld_skid) begin
            skid_data_reg <= fin_data_reg;
            skid_err_reg  <= fin_err_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(80-OUT_DW){1'b0}}, out_data_reg};
    assign m_tuser  = out_err_reg;

endmodule : frac_pll_divider_solver_top

`default_nettype wire

FILE: hdl/fpds_div_pipe.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider: NB quotient bits, up to SPS of them per stage.
module fpds_div_pipe #(
    parameter int NB  = 56,
    parameter int DW  = 34,
    parameter int SPS = 2,
    parameter int PW  = 1
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [NB-1:0] in_num,
    input  wire logic [DW-1:0] in_den,
    input  wire logic [PW-1:0] in_pay,
    output logic               out_valid,
    output logic [NB-1:0]      out_quo,
    output logic [PW-1:0]      out_pay
);

    localparam int NST = (NB + SPS - 1) / SPS;

    logic          v_reg   [NST];
    logic [NB-1:0] nq_reg  [NST];
    logic [DW-1:0] rem_reg [NST];
    logic [DW-1:0] den_reg [NST];
    logic [PW-1:0] pay_reg [NST];

    for (genvar s = 0; s < NST; s++) begin : g_stage
        localparam int FIRST = s * SPS;
        localparam int NSTEP = (NB - FIRST < SPS) ? (NB - FIRST) : SPS;

        logic          v_in;
        logic [NB-1:0] nq_in;
        logic [DW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [PW-1:0] pay_in;
        logic [NB-1:0] nq_next;
        logic [DW-1:0] rem_next;
        logic [DW:0]   r2;

        // Stage source: the ports for the first stage, the previous stage otherwise.
        if (s == 0) begin : g_first
            assign v_in   = in_valid;
            assign nq_in  = in_num;
            assign rem_in = '0;
            assign den_in = in_den;
            assign pay_in = in_pay;
        end else begin : g_rest
            assign v_in   = v_reg[s-1];
            assign nq_in  = nq_reg[s-1];
            assign rem_in = rem_reg[s-1];
            assign den_in = den_reg[s-1];
            assign pay_in = pay_reg[s-1];
        end

        // Dividend bits leave at the top while quotient bits enter at the bottom.
        always_comb begin
            nq_next  = nq_in;
            rem_next = rem_in;
            r2       = '0;
            for (int k = 0; k < NSTEP; k++) begin
                r2      = {rem_next, nq_next[NB-1]};
                nq_next = {nq_next[NB-2:0], 1'b0};
                if (r2 >= {1'b0, den_in}) begin
                    rem_next   = DW'(r2 - {1'b0, den_in});
                    nq_next[0] = 1'b1;
                end else begin
                    rem_next = r2[DW-1:0];
                end
            end
        end

        // Valid bit of this stage.
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[s] <= 1'b0;
            end else if (en) begin
                v_reg[s] <= v_in;
            end
        end

        // Data of this stage.
        always_ff @(posedge aclk) begin
            if (en) begin
                nq_reg[s]  <= nq_next;
                rem_reg[s] <= rem_next;
                den_reg[s] <= den_in;
                pay_reg[s] <= pay_in;
            end
        end
    end

    assign out_valid = v_reg[NST-1];
    assign out_quo   = nq_reg[NST-1];
    assign out_pay   = pay_reg[NST-1];

endmodule : fpds_div_pipe

`default_nettype wire

FILE: hdl/fpds_rate_prep.sv
`timescale 1ns / 1ps
`default_nettype none

// Field selection and range check, then the two products of the rate formula.
module fpds_rate_prep
    import fpds_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  wire logic [SOLVE_NB-1:0] in_quo,
    input  wire req_t                in_req,
    output logic                     out_valid,
    output logic [WHOLE_W-1:0]       out_whole,
    output logic [PART_W-1:0]        out_part,
    output logic [QDIV_W-1:0]        out_qdiv,
    output fields_t                  out_fields
);

    logic [RATE_IN_W-1:0] mult;
    logic                 range_bad;
    fields_t              sel_next;

    logic                 va_reg;
    fields_t              fa_reg;
    logic [PARENT_W-1:0]  pa_reg;

    logic                 vb_reg;
    logic [WHOLE_W-1:0]   whole_reg;
    logic [PART_W-1:0]    part_reg;
    logic [QDIV_W-1:0]    qdiv_reg;
    fields_t              fb_reg;

    logic [DEN_W+INT_W:0]     whole_prod;
    logic [PARENT_W+FRAC_W-1:0] part_prod;

    // Integer multiplier is the top part of the quotient, fraction the low part.
    assign mult      = in_quo[SOLVE_NB-1:FRAC_W];
    assign range_bad = (mult == '0) || (mult > RATE_IN_W'(MULT_MAX));

    always_comb begin
        if (in_req.kind == KIND_CALC) begin
            sel_next.out_div  = in_req.out_div;
            sel_next.int_div  = in_req.int_div;
            sel_next.frac_div = in_req.frac_div;
            sel_next.err      = 1'b0;
        end else if (range_bad) begin
            sel_next = '0;
            sel_next.err = 1'b1;
        end else begin
            sel_next.out_div  = '0;
            sel_next.int_div  = INT_W'(mult - RATE_IN_W'(1));
            sel_next.frac_div = in_quo[FRAC_W-1:0];
            sel_next.err      = 1'b0;
        end
    end

    // Products: 4*parent*(int+1) and parent*frac.
    assign whole_prod = {pa_reg, 2'b00} * {1'b0, fa_reg.int_div + INT_W'(0)} +
                        (DEN_W+INT_W+1)'({pa_reg, 2'b00});
    assign part_prod  = pa_reg * fa_reg.frac_div;

    // Valid bits of both stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else if (en) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    // Data of both stages.
    always_ff @(posedge aclk) begin
        if (en) begin
            fa_reg    <= sel_next;
            pa_reg    <= in_req.parent;
            whole_reg <= whole_prod[WHOLE_W-1:0];
            part_reg  <= part_prod[PARENT_W+FRAC_W-1:PART_SHIFT];
            qdiv_reg  <= {1'b0, fa_reg.out_div} + QDIV_W'(1);
            fb_reg    <= fa_reg;
        end
    end

    assign out_valid  = vb_reg;
    assign out_whole  = whole_reg;
    assign out_part   = part_reg;
    assign out_qdiv   = qdiv_reg;
    assign out_fields = fb_reg;

endmodule : fpds_rate_prep

`default_nettype wire
